>>> src/mbe_pkg.sv
// Shared types, widths and constants for the Mandelbrot escape-time grid block.
// No dependencies; used by every module under src.
`default_nettype none
package mbe_pkg;

  // fixed-point format: signed, 4 integer bits (sign included)
  localparam int FRAC_BITS = 28;
  localparam int FX_W      = FRAC_BITS + 4;
  localparam int SQ_W      = 2 * FX_W;
  localparam int SQ_HI_W   = SQ_W - FRAC_BITS;
  localparam int SUM_W     = SQ_HI_W + 12;

  // field and register widths
  localparam int COL_W      = 12;
  localparam int ROW_W      = 12;
  localparam int XSTEP_W    = 31;
  localparam int YSTEP_W    = 30;
  localparam int LIMIT_W    = 16;
  localparam int CNT_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;
  localparam int PX_W       = COL_W + XSTEP_W;
  localparam int PY_W       = ROW_W + YSTEP_W;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_X_STEP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_STEP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 2'd2;

  localparam logic [XSTEP_W-1:0] X_STEP_RST = XSTEP_W'(2982616);
  localparam logic [YSTEP_W-1:0] Y_STEP_RST = YSTEP_W'(1491308);
  localparam logic [LIMIT_W-1:0] LIMIT_RST  = LIMIT_W'(500);

  // queue between front and back end
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  typedef logic signed [FX_W-1:0]  fx_t;
  typedef logic signed [SUM_W-1:0] sum_t;

  localparam fx_t FX_MAX = {1'b0, {(FX_W-1){1'b1}}};
  localparam fx_t FX_MIN = {1'b1, {(FX_W-1){1'b0}}};

  // grid origin: -2 on the real axis, -1 on the imaginary axis
  localparam sum_t BASE_RE = -(SUM_W'(2) << FRAC_BITS);
  localparam sum_t BASE_IM = -(SUM_W'(1) << FRAC_BITS);

  // |z|^2 > 4 compared on full-width squares
  localparam logic [SQ_W:0] ESC_THRESH = (SQ_W+1)'(1) << (2 * FRAC_BITS + 2);

  typedef struct packed {
    fx_t cr;
    fx_t ci;
  } c_pair_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic fx_t sat_fx(input sum_t v);
    fx_t res;
    if (v > sum_t'(FX_MAX)) begin
      res = FX_MAX;
    end else if (v < sum_t'(FX_MIN)) begin
      res = FX_MIN;
    end else begin
      res = v[FX_W-1:0];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

>>> src/mandelbrot_escape_grid.sv
// Top level of the Mandelbrot escape-time grid block: configuration registers,
// front end, point queue and iteration back end. Depends on mbe_pkg and all src modules.
//
// Each pixel request (column, row) gives one escape count, in request order. The
// front end registers the scaled column and row on acceptance, forms c from them
// and parks it in a two-entry queue; the back end runs the z*z + c loop as a
// multiply state followed by an add state (add, saturate and escape test). Up to
// four pixels can be in flight (front stage, queue, back end) while a finished
// count waits to be popped.
// Change registers only when no pixel is in flight.
`default_nettype none
module mandelbrot_escape_grid (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            push,
  output logic                                 full,
  input  wire logic [mbe_pkg::COL_W-1:0]       in_column,
  input  wire logic [mbe_pkg::ROW_W-1:0]       in_row,
  output logic                                 empty,
  input  wire logic                            pop,
  output logic [mbe_pkg::CNT_W-1:0]            out_escape_count,
  input  wire logic                            cfg_we,
  input  wire logic [mbe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [mbe_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic [mbe_pkg::XSTEP_W-1:0]  x_step_r;
  logic [mbe_pkg::YSTEP_W-1:0]  y_step_r;
  logic [mbe_pkg::LIMIT_W-1:0]  limit_r;

  logic              q_push, q_pop;
  mbe_pkg::c_pair_t  q_wdata, q_rdata;
  mbe_pkg::q_stat_t  q_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_step_r <= mbe_pkg::X_STEP_RST;
      y_step_r <= mbe_pkg::Y_STEP_RST;
      limit_r  <= mbe_pkg::LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mbe_pkg::CFG_X_STEP: x_step_r <= cfg_data[mbe_pkg::XSTEP_W-1:0];
        mbe_pkg::CFG_Y_STEP: y_step_r <= cfg_data[mbe_pkg::YSTEP_W-1:0];
        mbe_pkg::CFG_LIMIT:  limit_r  <= cfg_data[mbe_pkg::LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  mbe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_column (in_column),
    .in_row    (in_row),
    .x_step    (x_step_r),
    .y_step    (y_step_r),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  mbe_cqueue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_wdata (q_wdata),
    .q_pop   (q_pop),
    .q_rdata (q_rdata),
    .q_stat  (q_stat)
  );

  mbe_core u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .iteration_limit  (limit_r),
    .q_stat           (q_stat),
    .q_rdata          (q_rdata),
    .q_pop            (q_pop),
    .empty            (empty),
    .pop              (pop),
    .out_escape_count (out_escape_count)
  );

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("back end took a point from an empty queue");

  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("front end pushed into a full queue");

  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |=> !q_stat.empty)
    else $error("pushed point lost from queue");

  a_stat_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty at once");

endmodule
`default_nettype wire

>>> src/mbe_front.sv
// Front end: takes pixel requests and turns column/row into the point c.
// Depends on mbe_pkg; feeds mbe_cqueue.
`default_nettype none
module mbe_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [mbe_pkg::COL_W-1:0]     in_column,
  input  wire logic [mbe_pkg::ROW_W-1:0]     in_row,
  input  wire logic [mbe_pkg::XSTEP_W-1:0]   x_step,
  input  wire logic [mbe_pkg::YSTEP_W-1:0]   y_step,
  input  wire mbe_pkg::q_stat_t              q_stat,
  output logic                               q_push,
  output mbe_pkg::c_pair_t                   q_data
);

  logic                      s1_valid_r;
  logic [mbe_pkg::PX_W-1:0]  px_r;
  logic [mbe_pkg::PY_W-1:0]  py_r;
  logic                      in_acc;
  mbe_pkg::sum_t             sum_re;
  mbe_pkg::sum_t             sum_im;

  assign q_push = s1_valid_r && !q_stat.full;
  assign full   = s1_valid_r && q_stat.full;
  assign in_acc = push && !full;

  assign sum_re = mbe_pkg::BASE_RE
                + mbe_pkg::sum_t'({{(mbe_pkg::SUM_W-mbe_pkg::PX_W){1'b0}}, px_r});
  assign sum_im = mbe_pkg::BASE_IM
                + mbe_pkg::sum_t'({{(mbe_pkg::SUM_W-mbe_pkg::PY_W){1'b0}}, py_r});

  assign q_data.cr = mbe_pkg::sat_fx(sum_re);
  assign q_data.ci = mbe_pkg::sat_fx(sum_im);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (q_push) begin
      s1_valid_r <= 1'b0;
    end
    if (in_acc) begin
      px_r <= mbe_pkg::PX_W'(in_column) * mbe_pkg::PX_W'(x_step);
      py_r <= mbe_pkg::PY_W'(in_row) * mbe_pkg::PY_W'(y_step);
    end
  end

endmodule
`default_nettype wire

>>> src/mbe_cqueue.sv
// Short queue of points c between the front and back ends.
// Depends on mbe_pkg.
`default_nettype none
module mbe_cqueue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_push,
  input  wire mbe_pkg::c_pair_t  q_wdata,
  input  wire logic              q_pop,
  output mbe_pkg::c_pair_t       q_rdata,
  output mbe_pkg::q_stat_t       q_stat
);

  mbe_pkg::c_pair_t             mem_r [mbe_pkg::Q_DEPTH];
  logic [mbe_pkg::Q_PTR_W-1:0]  wr_ptr_r;
  logic [mbe_pkg::Q_PTR_W-1:0]  rd_ptr_r;
  logic [mbe_pkg::Q_CNT_W-1:0]  cnt_r;

  function automatic logic [mbe_pkg::Q_PTR_W-1:0] ptr_inc(
    input logic [mbe_pkg::Q_PTR_W-1:0] p
  );
    logic [mbe_pkg::Q_PTR_W-1:0] res;
    if (p == mbe_pkg::Q_PTR_W'(mbe_pkg::Q_DEPTH - 1)) begin
      res = '0;
    end else begin
      res = p + 1'b1;
    end
    return res;
  endfunction

  assign q_stat.full  = (cnt_r == mbe_pkg::Q_CNT_W'(mbe_pkg::Q_DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign q_rdata      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (q_push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (q_pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (q_push && !q_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (q_pop && !q_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
    if (q_push) begin
      mem_r[wr_ptr_r] <= q_wdata;
    end
  end

endmodule
`default_nettype wire

>>> src/mbe_core.sv
// Back end: iterates z = z*z + c in a multiply state and an add state, and holds the result.
// Depends on mbe_pkg; takes points from mbe_cqueue.
`default_nettype none
module mbe_core (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [mbe_pkg::LIMIT_W-1:0]  iteration_limit,
  input  wire mbe_pkg::q_stat_t             q_stat,
  input  wire mbe_pkg::c_pair_t             q_rdata,
  output logic                              q_pop,
  output logic                              empty,
  input  wire logic                         pop,
  output logic [mbe_pkg::CNT_W-1:0]         out_escape_count
);

  typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_ADD} state_t;

  state_t                       state_r;
  mbe_pkg::fx_t                 cr_r, ci_r, zr_r, zi_r;
  logic [mbe_pkg::LIMIT_W-1:0]  k_r;
  logic [mbe_pkg::SQ_W-1:0]     rr_sq_r, ii_sq_r;
  logic signed [mbe_pkg::SQ_W-1:0] ri_r;
  logic signed [mbe_pkg::SQ_W-1:0] p_rr, p_ii, p_ri;
  logic [mbe_pkg::CNT_W-1:0]    res_r;
  logic                         res_valid_r;

  logic [mbe_pkg::SQ_W:0]       sq_sum;
  logic                         esc;
  logic                         at_limit;
  logic                         slot_free;
  logic                         res_load;
  mbe_pkg::sum_t                new_re, new_im;

  assign p_rr = zr_r * zr_r;
  assign p_ii = zi_r * zi_r;
  assign p_ri = zr_r * zi_r;

  // squares belong to the z produced by the previous step
  assign sq_sum   = {1'b0, rr_sq_r} + {1'b0, ii_sq_r};
  assign esc      = sq_sum > mbe_pkg::ESC_THRESH;
  assign at_limit = (k_r == iteration_limit);

  assign new_re = mbe_pkg::sum_t'({{(mbe_pkg::SUM_W-mbe_pkg::SQ_HI_W){1'b0}},
                                   rr_sq_r[mbe_pkg::SQ_W-1:mbe_pkg::FRAC_BITS]})
                - mbe_pkg::sum_t'({{(mbe_pkg::SUM_W-mbe_pkg::SQ_HI_W){1'b0}},
                                   ii_sq_r[mbe_pkg::SQ_W-1:mbe_pkg::FRAC_BITS]})
                + mbe_pkg::sum_t'(cr_r);
  // 2*zr*zi: one bit less shifted out, floor via arithmetic shift
  assign new_im = mbe_pkg::sum_t'({{(mbe_pkg::SUM_W-mbe_pkg::SQ_HI_W-1){ri_r[mbe_pkg::SQ_W-1]}},
                                   ri_r[mbe_pkg::SQ_W-1:mbe_pkg::FRAC_BITS-1]})
                + mbe_pkg::sum_t'(ci_r);

  assign slot_free        = !res_valid_r || pop;
  assign res_load         = (state_r == ST_ADD) && (esc || at_limit) && slot_free;
  assign q_pop            = (state_r == ST_IDLE) && !q_stat.empty;
  assign empty            = !res_valid_r;
  assign out_escape_count = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      res_valid_r <= 1'b0;
    end else begin
      if (res_load) begin
        res_valid_r <= 1'b1;
      end else if (pop) begin
        res_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (!q_stat.empty) begin
            cr_r    <= q_rdata.cr;
            ci_r    <= q_rdata.ci;
            zr_r    <= '0;
            zi_r    <= '0;
            k_r     <= '0;
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          rr_sq_r <= p_rr;
          ii_sq_r <= p_ii;
          ri_r    <= p_ri;
          state_r <= ST_ADD;
        end
        ST_ADD: begin
          if (esc || at_limit) begin
            // wait here until the result register can take the count
            if (slot_free) begin
              res_r   <= esc ? mbe_pkg::CNT_W'(k_r - 1'b1) : '0;
              state_r <= ST_IDLE;
            end
          end else begin
            zr_r    <= mbe_pkg::sat_fx(new_re);
            zi_r    <= mbe_pkg::sat_fx(new_im);
            k_r     <= k_r + 1'b1;
            state_r <= ST_MUL;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
